@@ design/etc_pkg.sv @@
// shared constants and helper functions for the epoch to calendar converter
package etc_pkg;

    localparam int unsigned EpochWidth   = 32;
    localparam int unsigned OffsetWidth  = 5;
    localparam int unsigned OutDataWidth = 96;
    localparam int unsigned DayNumWidth  = 17;

    localparam logic [11:0] BaseYear     = 12'd1970;
    localparam logic [33:0] SecsPerHour  = 34'd3600;
    localparam logic [33:0] LastSecond   = 34'd4102444799;

    // reciprocals for the constant divisions
    localparam logic [56:0] RecipDiv225  = 57'd305419896;
    localparam logic [29:0] RecipDiv60   = 30'd2185;
    localparam logic [37:0] RecipDiv3    = 38'd349526;
    localparam logic [33:0] RecipDiv1461 = 34'd91868;

    localparam logic [10:0] DaysOneYear    = 11'd365;
    localparam logic [10:0] DaysTwoYears   = 11'd730;
    localparam logic [10:0] DaysThreeYears = 11'd1096;
    localparam logic [16:0] DaysPerCycle   = 17'd1461;

    // first day of each month, counted from day 0 of the year
    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        unique case (m)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (m >= 4'd2)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

    // two bcd digits of a value below 100
    function automatic logic [7:0] bcd2(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 15'(v) * 15'd205;
        tens = prod[14:11];
        ones = v - 7'(tens) * 7'd10;
        return {tens, ones[3:0]};
    endfunction

endpackage

@@ design/etc_date_split.sv @@
// day count since 1970-01-01 to year, month and day, two pipeline stages
module etc_date_split (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [etc_pkg::DayNumWidth-1:0] i_day_num,
    output logic [11:0]                     o_year,
    output logic [3:0]                      o_month,
    output logic [4:0]                      o_day
);
    import etc_pkg::*;

    logic [6:0]             r_cycle;
    logic [DayNumWidth-1:0] r_day_num;
    logic [11:0]            r_year;
    logic                   r_leap;
    logic [8:0]             r_doy;

    logic [33:0]            w_cyc_prod;
    logic [DayNumWidth-1:0] w_cyc_rem;
    logic [10:0]            w_rem;
    logic [1:0]             w_yoff;
    logic [10:0]            w_ystart;
    logic [10:0]            w_doy_full;
    logic [11:0]            n_year;

    assign w_cyc_prod = 34'(i_day_num) * RecipDiv1461;

    always_comb begin
        w_cyc_rem = r_day_num - DayNumWidth'(r_cycle) * DaysPerCycle;
        w_rem     = w_cyc_rem[10:0];
        priority if (w_rem < DaysOneYear) begin
            w_yoff   = 2'd0;
            w_ystart = 11'd0;
        end else if (w_rem < DaysTwoYears) begin
            w_yoff   = 2'd1;
            w_ystart = DaysOneYear;
        end else if (w_rem < DaysThreeYears) begin
            w_yoff   = 2'd2;
            w_ystart = DaysTwoYears;
        end else begin
            w_yoff   = 2'd3;
            w_ystart = DaysThreeYears;
        end
        w_doy_full = w_rem - w_ystart;
        n_year     = BaseYear + (12'(r_cycle) << 2) + 12'(w_yoff);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cycle   <= w_cyc_prod[33:27];
            r_day_num <= i_day_num;
            r_year    <= n_year;
            r_leap    <= (w_yoff == 2'd2);
            r_doy     <= w_doy_full[8:0];
        end
    end

    logic [3:0] w_month;
    logic [8:0] w_base;
    logic [8:0] w_day_full;

    always_comb begin
        w_month = 4'd1;
        w_base  = 9'd0;
        for (int k = 1; k < 12; k++) begin
            if (r_doy >= month_start(4'(k), r_leap)) begin
                w_month = 4'(k + 1);
                w_base  = month_start(4'(k), r_leap);
            end
        end
        w_day_full = r_doy - w_base + 9'd1;
    end

    assign o_year  = r_year;
    assign o_month = w_month;
    assign o_day   = w_day_full[4:0];

endmodule

@@ design/epoch_to_calendar_time_core.sv @@
// top level: epoch seconds plus zone offset to binary and bcd calendar time
// One beat is taken every clock cycle unless the output stalls. The pipeline
// is a chain of constant-reciprocal multiplies (by 1/3600, 1/60, 1/24,
// 1/1461), each with a register behind it, and a final month lookup stage.
// The whole pipeline advances together and holds while a result waits on the
// output, so s_axis_tready follows the output side. The zone offset is
// written through i_cfg_we / i_cfg_wdata as a signed hour count and is
// applied to every beat. An adjusted time outside 1970 to 2099 gives a beat
// with tuser set and all data fields zero.
module epoch_to_calendar_time_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [etc_pkg::OffsetWidth-1:0]  i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // epoch_seconds
    input  logic [etc_pkg::EpochWidth-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // second_of_minute, minute_of_hour, hour_of_day, day_of_month,
    // month_of_year, year_number, time_bcd, date_bcd, zero pad
    output logic [etc_pkg::OutDataWidth-1:0] m_axis_tdata,
    // range_error
    output logic                             m_axis_tuser
);
    import etc_pkg::*;

    logic                         w_en;
    logic [7:0]                   r_vld;
    logic signed [OffsetWidth-1:0] r_utc_off;

    assign w_en          = !r_vld[7] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_utc_off <= '0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[6:0], s_axis_tvalid};
            end
            if (i_cfg_we) begin
                r_utc_off <= $signed(i_cfg_wdata);
            end
        end
    end

    // stage 1 input, stage 2 offset and span check
    logic [EpochWidth-1:0] r1_epoch;
    logic signed [33:0]    w_t;
    logic                  w_err;

    assign w_t   = $signed({2'b00, r1_epoch}) + 34'(r_utc_off) * $signed(SecsPerHour);
    assign w_err = (w_t < 34'sd0) || (w_t > $signed(LastSecond));

    logic [31:0] r2_t;
    logic        r2_err;
    logic [56:0] w_hq_prod;

    assign w_hq_prod = 57'(r2_t[31:4]) * RecipDiv225;

    // stage 3 hour quotient correction
    logic [20:0] r3_qa;
    logic [27:0] r3_x;
    logic [3:0]  r3_lo;
    logic        r3_err;
    logic [27:0] w_rr0;
    logic [8:0]  w_rr9;
    logic        w_fix;
    logic [8:0]  w_rr;
    logic [20:0] w_hours;

    always_comb begin
        w_rr0   = r3_x - 28'(29'(r3_qa) * 29'd225);
        w_rr9   = w_rr0[8:0];
        w_fix   = (w_rr9 >= 9'd225);
        w_rr    = w_fix ? (w_rr9 - 9'd225) : w_rr9;
        w_hours = r3_qa + 21'(w_fix);
    end

    // stage 4 split hours into days, split seconds of hour
    logic [20:0] r4_hours;
    logic [11:0] r4_sih;
    logic        r4_err;
    logic [29:0] w_min_prod;
    logic [5:0]  w_min;
    logic [11:0] w_sec_full;
    logic [37:0] w_day_prod;
    logic [DayNumWidth-1:0] w_day_num;
    logic [20:0] w_hr_full;

    always_comb begin
        w_min_prod = 30'(r4_sih) * RecipDiv60;
        w_min      = w_min_prod[22:17];
        w_sec_full = r4_sih - 12'(w_min) * 12'd60;
        w_day_prod = 38'(r4_hours[20:3]) * RecipDiv3;
        w_day_num  = w_day_prod[36:20];
        w_hr_full  = r4_hours - 21'(w_day_num) * 21'd24;
    end

    // stage 5 through 7 time fields ride alongside the date split
    logic [DayNumWidth-1:0] r5_day_num;
    logic [4:0]  r5_hr, r6_hr, r7_hr;
    logic [5:0]  r5_min, r6_min, r7_min;
    logic [5:0]  r5_sec, r6_sec, r7_sec;
    logic        r5_err, r6_err, r7_err;

    logic [11:0] w_year;
    logic [3:0]  w_month;
    logic [4:0]  w_day;

    etc_date_split u_date_split (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_day_num (r5_day_num),
        .o_year    (w_year),
        .o_month   (w_month),
        .o_day     (w_day)
    );

    logic [6:0]  w_ylo;
    logic [7:0]  w_yhi_bcd;
    logic [21:0] w_time_bcd;
    logic [29:0] w_date_bcd;
    logic [7:0]  w_hr_bcd, w_min_bcd, w_sec_bcd, w_day_bcd, w_mon_bcd, w_ylo_bcd;
    logic [OutDataWidth-1:0] n_out_data;

    always_comb begin
        if (w_year >= 12'd2000) begin
            w_ylo     = 7'(w_year - 12'd2000);
            w_yhi_bcd = 8'h20;
        end else begin
            w_ylo     = 7'(w_year - 12'd1900);
            w_yhi_bcd = 8'h19;
        end
        w_hr_bcd   = bcd2(7'(r7_hr));
        w_min_bcd  = bcd2(7'(r7_min));
        w_sec_bcd  = bcd2(7'(r7_sec));
        w_day_bcd  = bcd2(7'(w_day));
        w_mon_bcd  = bcd2(7'(w_month));
        w_ylo_bcd  = bcd2(w_ylo);
        w_time_bcd = {w_hr_bcd[5:0], w_min_bcd, w_sec_bcd};
        w_date_bcd = {w_day_bcd[5:0], w_mon_bcd, w_yhi_bcd, w_ylo_bcd};
        if (r7_err) begin
            n_out_data = '0;
        end else begin
            n_out_data = {6'd0, w_date_bcd, w_time_bcd, w_year, w_month, w_day,
                          r7_hr, r7_min, r7_sec};
        end
    end

    logic [OutDataWidth-1:0] r_out_data;
    logic                    r_out_err;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_epoch   <= s_axis_tdata;
            r2_t       <= w_t[31:0];
            r2_err     <= w_err;
            r3_qa      <= w_hq_prod[56:36];
            r3_x       <= r2_t[31:4];
            r3_lo      <= r2_t[3:0];
            r3_err     <= r2_err;
            r4_hours   <= w_hours;
            r4_sih     <= {w_rr[7:0], r3_lo};
            r4_err     <= r3_err;
            r5_day_num <= w_day_num;
            r5_hr      <= w_hr_full[4:0];
            r5_min     <= w_min;
            r5_sec     <= w_sec_full[5:0];
            r5_err     <= r4_err;
            r6_hr      <= r5_hr;
            r6_min     <= r5_min;
            r6_sec     <= r5_sec;
            r6_err     <= r5_err;
            r7_hr      <= r6_hr;
            r7_min     <= r6_min;
            r7_sec     <= r6_sec;
            r7_err     <= r6_err;
            r_out_data <= n_out_data;
            r_out_err  <= r7_err;
        end
    end

    assign m_axis_tdata = r_out_data;
    assign m_axis_tuser = r_out_err;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("range error beat carries nonzero data");

    a_date_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[25:22] >= 4'd1 && m_axis_tdata[25:22] <= 4'd12 &&
            m_axis_tdata[21:17] >= 5'd1 &&
            m_axis_tdata[37:26] >= 12'd1970 && m_axis_tdata[37:26] <= 12'd2099)
        else $error("date field out of range");

    a_time_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[5:0] < 6'd60 && m_axis_tdata[11:6] < 6'd60 &&
            m_axis_tdata[16:12] < 5'd24)
        else $error("time field out of range");
`endif

endmodule

@@ bench/epoch_to_calendar_time_core_tb.sv @@
// self-checking testbench for the epoch seconds to calendar time converter
`timescale 1ns / 100ps

typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [21:0] time_bcd;
    logic [29:0] date_bcd;
    logic        range_err;
} t_calendar;

class t_calendar_scoreboard;
    logic signed [etc_pkg::OffsetWidth-1:0] zone_hours;
    t_calendar pending_dates[$];
    int unsigned failures;

    function new();
        zone_hours = '0;
        failures   = 0;
    endfunction

    function automatic logic [7:0] to_bcd(int unsigned v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic t_calendar to_calendar(logic [31:0] epoch);
        t_calendar   r;
        longint      t;
        longint      days;
        longint      rem;
        longint      ylen;
        longint      mlen;
        int unsigned yr;
        int unsigned mon;
        int unsigned hr;
        int unsigned mn;
        int unsigned sc;
        int          mdays[12];
        mdays = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        r = '0;
        t = longint'(epoch) + longint'(zone_hours) * 3600;
        if (t < 0 || t > 64'd4102444799) begin
            r.range_err = 1'b1;
            return r;
        end
        days = t / 86400;
        rem  = t % 86400;
        sc   = rem % 60;
        mn   = (rem / 60) % 60;
        hr   = rem / 3600;
        yr   = 1970;
        forever begin
            ylen = (yr % 4 == 0) ? 366 : 365;
            if (days < ylen) break;
            days -= ylen;
            yr++;
        end
        mon = 1;
        for (int k = 0; k < 12; k++) begin
            mlen = (k == 1 && yr % 4 == 0) ? 29 : mdays[k];
            if (days < mlen) break;
            days -= mlen;
            mon++;
        end
        r.sec      = 6'(sc);
        r.min      = 6'(mn);
        r.hour     = 5'(hr);
        r.day      = 5'(days + 1);
        r.month    = 4'(mon);
        r.year     = 12'(yr);
        r.time_bcd = 22'({to_bcd(hr), to_bcd(mn), to_bcd(sc)});
        r.date_bcd = 30'({to_bcd(days + 1), to_bcd(mon), to_bcd(yr / 100), to_bcd(yr % 100)});
        return r;
    endfunction

    function void note_epoch(logic [31:0] epoch);
        pending_dates.push_back(to_calendar(epoch));
    endfunction

    function void compare_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    function void check_result(logic [etc_pkg::OutDataWidth-1:0] d, logic u);
        t_calendar want;
        if (pending_dates.size() == 0) begin
            $error("result beat with no pending date: tdata %h tuser %b", d, u);
            failures++;
            return;
        end
        want = pending_dates.pop_front();
        compare_field("second_of_minute", want.sec, d[5:0]);
        compare_field("minute_of_hour", want.min, d[11:6]);
        compare_field("hour_of_day", want.hour, d[16:12]);
        compare_field("day_of_month", want.day, d[21:17]);
        compare_field("month_of_year", want.month, d[25:22]);
        compare_field("year_number", want.year, d[37:26]);
        compare_field("time_bcd", want.time_bcd, d[59:38]);
        compare_field("date_bcd", want.date_bcd, d[89:60]);
        compare_field("pad", 0, d[95:90]);
        compare_field("range_error", want.range_err, u);
    endfunction
endclass

module epoch_to_calendar_time_core_tb;

    localparam longint CycleLimit = 400000;
    localparam logic [31:0] LastEpoch = 32'd4102444799;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [etc_pkg::OffsetWidth-1:0]  i_cfg_wdata;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    // epoch_seconds
    logic [etc_pkg::EpochWidth-1:0]   s_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b1;
    // second_of_minute, minute_of_hour, hour_of_day, day_of_month,
    // month_of_year, year_number, time_bcd, date_bcd, zero pad
    logic [etc_pkg::OutDataWidth-1:0] m_axis_tdata;
    // range_error
    logic                             m_axis_tuser;

    t_calendar_scoreboard sb;
    longint               cycles     = 0;
    int unsigned          sink_mode  = 0;
    int unsigned          sink_count = 0;

    epoch_to_calendar_time_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // receiver stall pattern, switching periodically to a randomly chosen style
    always @(negedge i_clk) begin
        sink_count <= sink_count + 1;
        if (sink_count % 300 == 299) begin
            sink_mode <= $urandom_range(3);
        end
        unique case (sink_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(1) == 1);
            2: m_axis_tready <= (sink_count % 7 < 3);
            default: m_axis_tready <= (sink_count % 16 < 2);
        endcase
    end

    task automatic send_beat(input logic [31:0] epoch);
        logic taken;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= epoch;
        do begin
            @(posedge i_clk);
            taken = s_axis_tready;
            if (taken) sb.note_epoch(epoch);
            @(negedge i_clk);
        end while (!taken);
    endtask

    task automatic idle_sender(input int unsigned n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_dates.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_offset(input logic signed [etc_pkg::OffsetWidth-1:0] hours);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= hours;
        sb.zone_hours = hours;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] random_epoch();
        longint t;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            t = $urandom_range(LastEpoch, 0);
        end else if (pick < 65) begin
            t = $urandom;
        end else if (pick < 75) begin
            t = $urandom_range(100000);
        end else if (pick < 85) begin
            t = longint'(LastEpoch) - 100000 + $urandom_range(200000);
        end else begin
            t = longint'($urandom_range(47481)) * 86400 + $urandom_range(7200) - 3600;
        end
        return 32'(t);
    endfunction

    task automatic random_phase(input int unsigned count);
        int unsigned sent;
        int unsigned burst;
        int unsigned drain_at;
        sent     = 0;
        drain_at = $urandom_range(count - 1, 1);
        while (sent < count) begin
            burst = ($urandom_range(9) == 0) ? 60 : $urandom_range(20, 1);
            for (int i = 0; i < burst && sent < count; i++) begin
                send_beat(random_epoch());
                sent++;
                if (sent == drain_at) drain();
            end
            if ($urandom_range(3) != 0) idle_sender($urandom_range(8, 1));
        end
    endtask

    initial begin
        logic [31:0] directed_utc[$];
        logic signed [etc_pkg::OffsetWidth-1:0] phase_offsets[8];
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset offset, year ends, month ends, leap days, span edges
        directed_utc = '{32'd0, 32'd59, 32'd3599, 32'd86399, 32'd86400, 32'd2678399,
                         32'd2678400, 32'd31535999, 32'd31536000, 32'd68169600,
                         32'd68255999, 32'd68256000, 32'd951782400, 32'd1709164800,
                         LastEpoch, LastEpoch + 1, 32'hFFFFFFFF, 32'h80000000,
                         32'h7FFFFFFF, 32'h55555555, 32'hAAAAAAAA};
        foreach (directed_utc[i]) send_beat(directed_utc[i]);

        // negative offset pushes the start of the span out of range
        write_offset(-5'sd12);
        send_beat(32'd0);
        send_beat(32'd43199);
        send_beat(32'd43200);
        // positive offset pushes the end of the span out of range
        write_offset(5'sd14);
        send_beat(32'd4102394399);
        send_beat(32'd4102394400);

        phase_offsets = '{-5'sd16, 5'sd15, -5'sd12, 5'sd14, -5'sd1, 5'sd0, 5'sd1, 5'sd0};
        phase_offsets[7] = 5'($urandom_range(31));
        foreach (phase_offsets[p]) begin
            write_offset(phase_offsets[p]);
            random_phase(100);
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending_dates.size() != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/etc_pkg.sv
design/etc_date_split.sv
design/epoch_to_calendar_time_core.sv
bench/epoch_to_calendar_time_core_tb.sv
